// ----- design/hex_lattice_gas_cell_update_macros.svh -----
// ----------------------------------------------------------------------------
// Hex lattice gas cell update: assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef HEX_LATTICE_GAS_CELL_UPDATE_MACROS_SVH
`define HEX_LATTICE_GAS_CELL_UPDATE_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define HLGCU_ASSERT_NOW(label, rstn, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define HLGCU_ASSERT_NEXT(label, rstn, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/hlgcu_pkg.sv -----
// ----------------------------------------------------------------------------
// Hex lattice gas cell update: shared package
// Types, codes and the collision rule of the hexagonal lattice gas.
// ----------------------------------------------------------------------------
`default_nettype none

package hlgcu_pkg;

    localparam int MASK_W        = 6;
    localparam int CELL_W        = 2 * MASK_W;
    localparam int COORD_W       = 8;
    localparam int DIM_W         = 8;
    localparam int COUNT_W       = 4;
    localparam int HOP_W         = 3;
    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;

    localparam logic [DIM_W-1:0] DIM_RESET = 8'd128;
    localparam logic [HOP_W-1:0] HOP_LAST  = 3'd5;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // head-on pairs and quads
    localparam logic [MASK_W-1:0] PAIR_A = 6'd9;
    localparam logic [MASK_W-1:0] PAIR_B = 6'd18;
    localparam logic [MASK_W-1:0] PAIR_C = 6'd36;
    localparam logic [MASK_W-1:0] QUAD_A = 6'd27;
    localparam logic [MASK_W-1:0] QUAD_B = 6'd45;
    localparam logic [MASK_W-1:0] QUAD_C = 6'd54;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_HOP,
        ST_DONE
    } state_t;

    // fixed swap pairs; every other mask maps to itself
    function automatic logic [MASK_W-1:0] swap_mask(input logic [MASK_W-1:0] m);
        logic [MASK_W-1:0] r;
        case (m)
            6'd11:   r = 6'd38;
            6'd38:   r = 6'd11;
            6'd13:   r = 6'd22;
            6'd22:   r = 6'd13;
            6'd19:   r = 6'd37;
            6'd37:   r = 6'd19;
            6'd21:   r = 6'd42;
            6'd42:   r = 6'd21;
            6'd25:   r = 6'd52;
            6'd52:   r = 6'd25;
            6'd26:   r = 6'd44;
            6'd44:   r = 6'd26;
            6'd41:   r = 6'd50;
            6'd50:   r = 6'd41;
            default: r = m;
        endcase
        return r;
    endfunction

    function automatic logic [MASK_W-1:0] collide(input logic [MASK_W-1:0] m,
                                                  input logic left);
        logic [MASK_W-1:0] r;
        case (m) inside
            PAIR_A, PAIR_B, PAIR_C, QUAD_A, QUAD_B, QUAD_C: begin
                r = left ? {m[MASK_W-2:0], m[MASK_W-1]} : {m[0], m[MASK_W-1:1]};
            end
            default: r = swap_mask(m);
        endcase
        return r;
    endfunction

    // incoming slot that outgoing bit k lands in at its neighbor
    function automatic logic [HOP_W-1:0] opposite(input logic [HOP_W-1:0] k);
        logic [HOP_W-1:0] r;
        case (k)
            3'd0:    r = 3'd3;
            3'd1:    r = 3'd4;
            3'd2:    r = 3'd5;
            3'd3:    r = 3'd0;
            3'd4:    r = 3'd1;
            default: r = 3'd2;
        endcase
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] popcount(input logic [CELL_W-1:0] c);
        logic [COUNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < CELL_W; i++) begin
            n = n + COUNT_W'(c[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- design/hlgcu_cell_ram.sv -----
// ----------------------------------------------------------------------------
// Hex lattice gas cell update: cell store
// One write port and one read port, read data registered (read-old on clash).
// ----------------------------------------------------------------------------
`default_nettype none

module hlgcu_cell_ram #(
    parameter int DEPTH = hlgcu_pkg::MAX_WIDTH_DEF * hlgcu_pkg::MAX_HEIGHT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [hlgcu_pkg::CELL_W-1:0]  wr_data,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [hlgcu_pkg::CELL_W-1:0]  rd_data
);

    logic [hlgcu_pkg::CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/hlgcu_cell_rule.sv -----
// ----------------------------------------------------------------------------
// Hex lattice gas cell update: cell rule
// Collide the incoming mask, then move incoming bits to free outgoing slots.
// ----------------------------------------------------------------------------
`default_nettype none

module hlgcu_cell_rule (
    input  wire logic [hlgcu_pkg::CELL_W-1:0] cell_in,
    input  wire logic                         rotate_left,
    output logic      [hlgcu_pkg::CELL_W-1:0] cell_out
);

    logic [hlgcu_pkg::MASK_W-1:0] in_col;
    logic [hlgcu_pkg::MASK_W-1:0] out_old;

    always_comb begin
        in_col  = hlgcu_pkg::collide(cell_in[hlgcu_pkg::MASK_W-1:0], rotate_left);
        out_old = cell_in[hlgcu_pkg::CELL_W-1:hlgcu_pkg::MASK_W];
        // a bit moves out where the slot is free, stays in where it is taken
        cell_out = {out_old | in_col, in_col & out_old};
    end

endmodule

`default_nettype wire

// ----- design/hex_lattice_gas_cell_update.sv -----
// ----------------------------------------------------------------------------
// Hex lattice gas cell update
// Cell store of a hexagonal lattice gas with load, read and single-cell update.
// ----------------------------------------------------------------------------
//  Channel  | Ports                       | Contents (lowest bit first)
//  ---------+-----------------------------+------------------------------------
//  input    | s_tvalid s_tready s_tdata   | tdata: cell_x, cell_y, rotate_left,
//           | s_tuser                     |   load_incoming, load_outgoing
//           |                             | tuser: kind
//  result   | m_tvalid m_tready m_tdata   | tdata: incoming_mask, outgoing_mask,
//           | m_tuser                     |   particle_count; tuser: status
//  config   | cfg_wr_en cfg_index         | index 0 grid_width, 1 grid_height
//           | cfg_wdata                   |
//
//  One item at a time. A load or an out-of-range item goes from accept
//  straight to the finish step, a read first fetches the cell, and an update
//  is paced by the single read port of the cell store: it fetches the cell,
//  then does one read-modify-write per neighbor for the six hops, then finishes.
//  A held result stalls only the finish step; the next item is taken as soon
//  as the result is in the output register. Reset (aresetn low, synchronous)
//  clears control state and sets both grid dimensions to 128; the cell store
//  is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hex_lattice_gas_cell_update_macros.svh"

module hex_lattice_gas_cell_update #(
    parameter int MAX_WIDTH  = hlgcu_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hlgcu_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // cell_x[6:0], cell_y[13:7], rotate_left[14],
                                        // load_incoming[20:15], load_outgoing[26:21]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // incoming_mask[5:0], outgoing_mask[11:6],
                                        // particle_count[15:12]
    output logic [0:0]       m_tuser    // status[0]
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = hlgcu_pkg::COORD_W;
    localparam int MW    = hlgcu_pkg::MASK_W;
    localparam int LW    = hlgcu_pkg::CELL_W;
    localparam int HW    = hlgcu_pkg::HOP_W;

    // ------------------------------------------------------------------
    // Configuration registers and effective grid size
    // ------------------------------------------------------------------
    logic [hlgcu_pkg::DIM_W-1:0] width_reg;
    logic [hlgcu_pkg::DIM_W-1:0] height_reg;
    logic [CW-1:0]               w_eff;
    logic [CW-1:0]               h_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= hlgcu_pkg::DIM_RESET;
            height_reg <= hlgcu_pkg::DIM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hlgcu_pkg::REG_WIDTH:  width_reg  <= cfg_wdata;
                hlgcu_pkg::REG_HEIGHT: height_reg <= cfg_wdata;
            endcase
        end
    end

    // clamp to the store's dimensions
    assign w_eff = (32'(width_reg) > 32'(MAX_WIDTH))   ? CW'(MAX_WIDTH)  : width_reg;
    assign h_eff = (32'(height_reg) > 32'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : height_reg;

    // ------------------------------------------------------------------
    // Input unpacking, range check and wrapped neighbor coordinates
    // ------------------------------------------------------------------
    hlgcu_pkg::kind_t in_kind;
    logic [CW-1:0]    in_x;
    logic [CW-1:0]    in_y;
    logic             in_left;
    logic [MW-1:0]    in_lin;
    logic [MW-1:0]    in_lout;
    logic             in_range;
    logic [CW-1:0]    in_xm, in_xp, in_ym, in_yp;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] cx,
                                                input logic [CW-1:0] cy);
        return AW'(AW'(cx) * AW'(MAX_HEIGHT)) + AW'(cy);
    endfunction

    assign in_kind  = hlgcu_pkg::kind_t'(s_tuser);
    assign in_x     = {1'b0, s_tdata[6:0]};
    assign in_y     = {1'b0, s_tdata[13:7]};
    assign in_left  = s_tdata[14];
    assign in_lin   = s_tdata[20:15];
    assign in_lout  = s_tdata[26:21];
    assign in_range = (in_x < w_eff) && (in_y < h_eff);
    assign in_xm    = (in_x == '0) ? w_eff - 1'b1 : in_x - 1'b1;
    assign in_xp    = (in_x + 1'b1 >= w_eff) ? '0 : in_x + 1'b1;
    assign in_ym    = (in_y == '0) ? h_eff - 1'b1 : in_y - 1'b1;
    assign in_yp    = (in_y + 1'b1 >= h_eff) ? '0 : in_y + 1'b1;

    // ------------------------------------------------------------------
    // Item context, held for the whole update
    // ------------------------------------------------------------------
    hlgcu_pkg::kind_t kind_reg;
    logic             left_reg;
    logic             oor_reg;
    logic [AW-1:0]    c_addr_reg;
    logic [CW-1:0]    x_reg, y_reg, xm_reg, xp_reg, ym_reg, yp_reg;
    logic [AW-1:0]    dst_addr_reg, dst_addr_next;
    logic [LW-1:0]    cur_reg, cur_next;
    logic             accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg   <= in_kind;
            left_reg   <= in_left;
            oor_reg    <= !in_range;
            c_addr_reg <= cell_addr(in_x, in_y);
            x_reg      <= in_x;
            y_reg      <= in_y;
            xm_reg     <= in_xm;
            xp_reg     <= in_xp;
            ym_reg     <= in_ym;
            yp_reg     <= in_yp;
        end
        dst_addr_reg <= dst_addr_next;
        cur_reg      <= cur_next;
    end

    // ------------------------------------------------------------------
    // Cell store and write forwarding
    // ------------------------------------------------------------------
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [LW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [LW-1:0] mem_rdata;
    logic          fwd_en_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [LW-1:0] fwd_data_reg;

    hlgcu_cell_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cell_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // a read issued on the same edge as a write returns the old entry;
    // keep the write so that the next hop can pick it up instead
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_en_reg <= 1'b0;
        end else begin
            fwd_en_reg <= mem_we;
        end
        fwd_addr_reg <= mem_waddr;
        fwd_data_reg <= mem_wdata;
    end

    // ------------------------------------------------------------------
    // Neighbor address for the next read
    // ------------------------------------------------------------------
    hlgcu_pkg::state_t state_reg, state_next;
    logic [HW-1:0]     hop_reg, hop_next;
    logic [HW-1:0]     nbr_sel;
    logic [CW-1:0]     nbr_x, nbr_y;
    logic [AW-1:0]     nbr_addr;

    assign nbr_sel = (state_reg == hlgcu_pkg::ST_FETCH) ? '0 : hop_reg + 1'b1;

    always_comb begin
        case (nbr_sel)
            3'd0:    begin nbr_x = xm_reg; nbr_y = y_reg;  end
            3'd1:    begin nbr_x = xm_reg; nbr_y = yp_reg; end
            3'd2:    begin nbr_x = x_reg;  nbr_y = yp_reg; end
            3'd3:    begin nbr_x = xp_reg; nbr_y = yp_reg; end
            3'd4:    begin nbr_x = xp_reg; nbr_y = y_reg;  end
            default: begin nbr_x = x_reg;  nbr_y = ym_reg; end
        endcase
        nbr_addr = cell_addr(nbr_x, nbr_y);
    end

    // ------------------------------------------------------------------
    // Hop of one outgoing bit into its neighbor
    // ------------------------------------------------------------------
    logic          dst_self;
    logic [LW-1:0] dst_val;
    logic [HW-1:0] dst_slot;
    logic [MW-1:0] src_bit, dst_bit;
    logic          dst_full;
    logic          hop_move;

    always_comb begin
        dst_self = (dst_addr_reg == c_addr_reg);
        dst_val  = (fwd_en_reg && (fwd_addr_reg == dst_addr_reg)) ? fwd_data_reg : mem_rdata;
        dst_slot = hlgcu_pkg::opposite(hop_reg);
        src_bit  = MW'(1) << hop_reg;
        dst_bit  = MW'(1) << dst_slot;
        // the center cell lives in cur_reg while the update runs
        dst_full = dst_self ? |(cur_reg[MW-1:0] & dst_bit) : |(dst_val[MW-1:0] & dst_bit);
        hop_move = |(cur_reg[LW-1:MW] & src_bit) && !dst_full;
    end

    // ------------------------------------------------------------------
    // Collision and result
    // ------------------------------------------------------------------
    logic [LW-1:0] rule_cell;
    logic [LW-1:0] res_cell;
    logic          m_tvalid_reg;
    logic [15:0]   m_tdata_reg;
    logic [0:0]    m_tuser_reg;
    logic          out_load;
    logic          can_emit;

    hlgcu_cell_rule u_cell_rule (
        .cell_in     (cur_reg),
        .rotate_left (left_reg),
        .cell_out    (rule_cell)
    );

    always_comb begin
        if (oor_reg) begin
            res_cell = '0;
        end else if (kind_reg == hlgcu_pkg::KIND_UPDATE) begin
            res_cell = rule_cell;
        end else begin
            res_cell = cur_reg;
        end
    end

    assign can_emit = !m_tvalid_reg || m_tready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hlgcu_pkg::ST_IDLE;
            hop_reg   <= '0;
        end else begin
            state_reg <= state_next;
            hop_reg   <= hop_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        hop_next      = hop_reg;
        cur_next      = cur_reg;
        dst_addr_next = dst_addr_reg;
        mem_we        = 1'b0;
        mem_waddr     = c_addr_reg;
        mem_wdata     = cur_reg;
        mem_re        = 1'b0;
        mem_raddr     = nbr_addr;
        out_load      = 1'b0;
        s_tready      = 1'b0;

        unique case (state_reg)
            hlgcu_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                mem_raddr = cell_addr(in_x, in_y);
                mem_waddr = cell_addr(in_x, in_y);
                if (s_tvalid) begin
                    if (!in_range) begin
                        state_next = hlgcu_pkg::ST_DONE;
                    end else begin
                        case (in_kind)
                            hlgcu_pkg::KIND_LOAD: begin
                                mem_we     = 1'b1;
                                mem_wdata  = {in_lout, in_lin};
                                cur_next   = {in_lout, in_lin};
                                state_next = hlgcu_pkg::ST_DONE;
                            end
                            default: begin
                                // update and read both start by fetching the cell
                                mem_re     = 1'b1;
                                state_next = hlgcu_pkg::ST_FETCH;
                            end
                        endcase
                    end
                end
            end
            hlgcu_pkg::ST_FETCH: begin
                cur_next = mem_rdata;
                if (kind_reg == hlgcu_pkg::KIND_UPDATE) begin
                    mem_re        = 1'b1;
                    dst_addr_next = nbr_addr;
                    hop_next      = '0;
                    state_next    = hlgcu_pkg::ST_HOP;
                end else begin
                    state_next = hlgcu_pkg::ST_DONE;
                end
            end
            hlgcu_pkg::ST_HOP: begin
                if (hop_move) begin
                    cur_next[LW-1:MW] = cur_reg[LW-1:MW] & ~src_bit;
                    if (dst_self) begin
                        cur_next[MW-1:0] = cur_reg[MW-1:0] | dst_bit;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = dst_addr_reg;
                        mem_wdata = dst_val | LW'(dst_bit);
                    end
                end
                if (hop_reg == hlgcu_pkg::HOP_LAST) begin
                    state_next = hlgcu_pkg::ST_DONE;
                end else begin
                    // fetch the next neighbor while this one is written back
                    mem_re        = 1'b1;
                    dst_addr_next = nbr_addr;
                    hop_next      = hop_reg + 1'b1;
                end
            end
            hlgcu_pkg::ST_DONE: begin
                if (can_emit) begin
                    out_load   = 1'b1;
                    state_next = hlgcu_pkg::ST_IDLE;
                    if (!oor_reg && kind_reg == hlgcu_pkg::KIND_UPDATE) begin
                        mem_we    = 1'b1;
                        mem_wdata = rule_cell;
                    end
                end
            end
            default: begin
                state_next = hlgcu_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (out_load) begin
            m_tdata_reg <= {hlgcu_pkg::popcount(res_cell), res_cell};
            m_tuser_reg <= oor_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `HLGCU_ASSERT_NOW(a_hop_skips_center, aresetn,
        mem_we && (state_reg == hlgcu_pkg::ST_HOP), mem_waddr != c_addr_reg,
        "hop wrote the center cell to the store")
    `HLGCU_ASSERT_NOW(a_hop_in_range, aresetn,
        state_reg == hlgcu_pkg::ST_HOP, hop_reg <= hlgcu_pkg::HOP_LAST,
        "hop counter past the last direction")
    `HLGCU_ASSERT_NOW(a_oor_zero, aresetn,
        m_tvalid && m_tuser[0], m_tdata == '0,
        "out-of-range result carries a payload")
    `HLGCU_ASSERT_NEXT(a_finish_waits, aresetn,
        (state_reg == hlgcu_pkg::ST_DONE) && m_tvalid_reg && !m_tready,
        state_reg == hlgcu_pkg::ST_DONE,
        "finish step left while the output register was full")

endmodule

`default_nettype wire
